FILE: design/dtc_pkg.sv
// shared types, constants and functions for distance_to_color_and_tone
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

    localparam int LEVEL_W = 31;
    localparam int HUE_W   = 8;
    localparam int COLOR_W = 8;
    localparam int TONE_W  = 10;
    localparam int GAIN_W  = 17;
    localparam int LIMIT_W = 9;
    localparam int CFG_W   = 17;
    localparam int INDEX_W = 3;
    localparam int EMA_W   = 49;

    localparam logic [INDEX_W-1:0] REG_NEAR_LIMIT = 3'd0;
    localparam logic [INDEX_W-1:0] REG_FAR_LIMIT  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_HUE_NEAR   = 3'd2;
    localparam logic [INDEX_W-1:0] REG_HUE_FAR    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_GAIN       = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'd65536;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 31'h7FFF_FFFF;

    // divider handshake back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_nonzero;
    } dtc_div_status_t;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_DIST   = 12'b0000_0000_0010,
        ST_EMA    = 12'b0000_0000_0100,
        ST_ROUND  = 12'b0000_0000_1000,
        ST_CMP    = 12'b0000_0001_0000,
        ST_SPAN   = 12'b0000_0010_0000,
        ST_HSTART = 12'b0000_0100_0000,
        ST_HWAIT  = 12'b0000_1000_0000,
        ST_KSTART = 12'b0001_0000_0000,
        ST_KWAIT  = 12'b0010_0000_0000,
        ST_FIN    = 12'b0100_0000_0000,
        ST_LOAD   = 12'b1000_0000_0000
    } dtc_state_t;

    function automatic logic [TONE_W-1:0] note_hz(input logic [2:0] idx);
        logic [TONE_W-1:0] hz;
        unique case (idx)
            3'd0:    hz = 10'd261;
            3'd1:    hz = 10'd294;
            3'd2:    hz = 10'd330;
            3'd3:    hz = 10'd349;
            3'd4:    hz = 10'd392;
            3'd5:    hz = 10'd440;
            3'd6:    hz = 10'd493;
            default: hz = 10'd523;
        endcase
        return hz;
    endfunction

    // hsv to rgb at full saturation and value, returns {r, g, b}
    function automatic logic [3*COLOR_W-1:0] hue_to_rgb(input logic [HUE_W-1:0] hue);
        logic [10:0]        h6;
        logic [2:0]         region;
        logic [COLOR_W-1:0] t;
        logic [COLOR_W-1:0] q;
        logic [3*COLOR_W-1:0] rgb;
        h6     = 11'(hue) * 11'd6;
        region = h6[10:8];
        t      = h6[7:0];
        q      = 8'd255 - t;
        unique case (region)
            3'd0:    rgb = {8'd255, t, 8'd0};
            3'd1:    rgb = {q, 8'd255, 8'd0};
            3'd2:    rgb = {8'd0, 8'd255, t};
            3'd3:    rgb = {8'd0, q, 8'd255};
            3'd4:    rgb = {t, 8'd0, 8'd255};
            default: rgb = {8'd255, 8'd0, q};
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

FILE: design/dtc_divider.sv
// restoring divider, one quotient bit per cycle, eight quotient bits
// depends on dtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtc_divider
    import dtc_pkg::*;
#(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 25
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic [HUE_W-1:0]           quotient,
    output dtc_div_status_t            status
);

    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dsr_reg, dsr_next;
    logic [HUE_W-1:0]      quo_reg, quo_next;
    logic [2:0]            step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  fits;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        fits      = rem_reg >= dsr_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = DIVIDEND_W'(divisor) << (HUE_W - 1);
            quo_next  = '0;
            step_next = 3'(HUE_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            quo_next = {quo_reg[HUE_W-2:0], fits};
            dsr_next = dsr_reg >> 1;
            if (step_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient           = quo_reg;
    assign status.done        = done_reg;
    assign status.rem_nonzero = rem_reg != '0;

endmodule

`default_nettype wire

FILE: design/distance_to_color_and_tone.sv
// top level: echo width to smoothed distance, color and note
// depends on dtc_pkg and dtc_divider
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel in_valid/in_ready carries one echo width and a sound enable
//   output channel out_valid/out_ready carries one color, note and level
//   configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   user must write only while idle (not enforced); unknown indexes ignored
// timing
//   one item is worked at a time by a bit-serial sequencer
//   nonzero echo: serial distance multiply, then serial smoothing multiply
//   (the first reading loads the average instead), then the ratio stage
//   ratio stage: serial span multiply, two serial divisions
//   a zero echo skips the multiplies and goes straight to the compare;
//   an average outside the limits skips straight to the result
// stalls and reset
//   the result sits in an output register; a new item is taken while it
//   waits, and the next result is held back until the old one is taken
//   reset restores the register defaults, clears the average and arms the
//   first-reading load

module distance_to_color_and_tone
    import dtc_pkg::*;
#(
    parameter int WIDTH_BITS = 20,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [WIDTH_BITS-1:0] echo_us,
    input  wire logic                  sound_enable,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COLOR_W-1:0]         red,
    output logic [COLOR_W-1:0]         green,
    output logic [COLOR_W-1:0]         blue,
    output logic [TONE_W-1:0]          tone_hz,
    output logic                       tone_on,
    output logic [LEVEL_W-1:0]         level_q16
);

    // cm per microsecond times 2^FRAC_BITS, rounded
    localparam int DIST_SCALE = (17 * (1 << FRAC_BITS) + 500) / 1000;
    localparam int SCALE_W    = $clog2(DIST_SCALE + 1);
    localparam int MUL_W      = WIDTH_BITS + SCALE_W;
    localparam int NUM_W      = LIMIT_W + FRAC_BITS;
    localparam int DIV_W      = NUM_W + HUE_W;
    localparam int CNT_W      = $clog2((WIDTH_BITS > GAIN_W) ? WIDTH_BITS : GAIN_W);

    dtc_state_t state_reg, state_next;

    // configuration
    logic [LIMIT_W-1:0] near_reg, far_reg;
    logic [HUE_W-1:0]   hue_near_reg, hue_far_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // smoother state
    logic [LEVEL_W-1:0] avg_reg, avg_next;
    logic               first_reg, first_next;

    // working registers
    logic [WIDTH_BITS-1:0] echo_reg, echo_next;
    logic                  en_reg, en_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [MUL_W-1:0]      mul_reg, mul_next;
    logic [LEVEL_W-1:0]    dist_reg, dist_next;
    logic [GAIN_W-1:0]     g_reg, g_next;
    logic [GAIN_W-1:0]     h_reg, h_next;
    logic [EMA_W-1:0]      ema_reg, ema_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [NUM_W-1:0]      den_reg, den_next;
    logic [HUE_W-1:0]      span_reg, span_next;
    logic                  up_reg, up_next;
    logic [DIV_W-1:0]      sp_reg, sp_next;
    logic [HUE_W-1:0]      hue_reg, hue_next;
    logic [2:0]            note_reg, note_next;

    // output register
    logic                  ov_reg, ov_next;
    logic [3*COLOR_W-1:0]  rgb_reg, rgb_next;
    logic [TONE_W-1:0]     tone_reg, tone_next;
    logic                  ton_reg, ton_next;
    logic [LEVEL_W-1:0]    lvl_reg, lvl_next;

    // divider hookup
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [HUE_W-1:0]      div_quo;
    dtc_div_status_t       div_status;

    logic [LEVEL_W-1:0]    near_q, far_q;
    logic [GAIN_W-1:0]     gain_sat;
    logic [EMA_W-1:0]      ema_round;

    assign near_q    = LEVEL_W'(near_reg) << FRAC_BITS;
    assign far_q     = LEVEL_W'(far_reg) << FRAC_BITS;
    assign gain_sat  = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign ema_round = ema_reg + EMA_W'(32768);

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = ov_reg;
    assign red       = rgb_reg[3*COLOR_W-1:2*COLOR_W];
    assign green     = rgb_reg[2*COLOR_W-1:COLOR_W];
    assign blue      = rgb_reg[COLOR_W-1:0];
    assign tone_hz   = tone_reg;
    assign tone_on   = ton_reg;
    assign level_q16 = lvl_reg;

    assign div_start    = (state_reg == ST_HSTART) || (state_reg == ST_KSTART);
    assign div_dividend = (state_reg == ST_HSTART) ? sp_reg
                                                   : (DIV_W'(num_reg) << 3);

    dtc_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        avg_next   = avg_reg;
        first_next = first_reg;
        echo_next  = echo_reg;
        en_next    = en_reg;
        cnt_next   = cnt_reg;
        mul_next   = mul_reg;
        dist_next  = dist_reg;
        g_next     = g_reg;
        h_next     = h_reg;
        ema_next   = ema_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        span_next  = span_reg;
        up_next    = up_reg;
        sp_next    = sp_reg;
        hue_next   = hue_reg;
        note_next  = note_reg;
        ov_next    = ov_reg;
        rgb_next   = rgb_reg;
        tone_next  = tone_reg;
        ton_next   = ton_reg;
        lvl_next   = lvl_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    echo_next = echo_us;
                    en_next   = sound_enable;
                    mul_next  = '0;
                    cnt_next  = CNT_W'(WIDTH_BITS - 1);
                    state_next = (echo_us == '0) ? ST_CMP : ST_DIST;
                end
            end
            ST_DIST:
            begin
                // msb-first shift-add of echo times scale
                mul_next  = (mul_reg << 1)
                          + (echo_reg[WIDTH_BITS-1] ? MUL_W'(DIST_SCALE) : '0);
                echo_next = echo_reg << 1;
                if (cnt_reg == '0)
                begin
                    if (mul_next > MUL_W'(LEVEL_MAX))
                    begin
                        dist_next = LEVEL_MAX;
                    end
                    else
                    begin
                        dist_next = LEVEL_W'(mul_next);
                    end
                    if (first_reg)
                    begin
                        avg_next   = dist_next;
                        first_next = 1'b0;
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        g_next     = gain_sat;
                        h_next     = GAIN_ONE - gain_sat;
                        ema_next   = '0;
                        cnt_next   = CNT_W'(GAIN_W - 1);
                        state_next = ST_EMA;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMA:
            begin
                // both weights walked msb-first together
                ema_next = (ema_reg << 1)
                         + (g_reg[GAIN_W-1] ? EMA_W'(dist_reg) : '0)
                         + (h_reg[GAIN_W-1] ? EMA_W'(avg_reg) : '0);
                g_next = g_reg << 1;
                h_next = h_reg << 1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ROUND:
            begin
                avg_next   = ema_round[LEVEL_W+15:16];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (avg_reg <= near_q)
                begin
                    hue_next   = hue_near_reg;
                    note_next  = 3'd0;
                    state_next = ST_FIN;
                end
                else if (avg_reg >= far_q)
                begin
                    hue_next   = hue_far_reg;
                    note_next  = 3'd7;
                    state_next = ST_FIN;
                end
                else
                begin
                    num_next  = NUM_W'(avg_reg - near_q);
                    den_next  = NUM_W'(far_q - near_q);
                    up_next   = hue_far_reg >= hue_near_reg;
                    span_next = (hue_far_reg >= hue_near_reg) ? hue_far_reg - hue_near_reg
                                                              : hue_near_reg - hue_far_reg;
                    sp_next   = '0;
                    cnt_next  = CNT_W'(HUE_W - 1);
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                sp_next   = (sp_reg << 1) + (span_reg[HUE_W-1] ? DIV_W'(num_reg) : '0);
                span_next = span_reg << 1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_HSTART;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_HSTART:
            begin
                state_next = ST_HWAIT;
            end
            ST_HWAIT:
            begin
                if (div_status.done)
                begin
                    hue_next   = up_reg ? hue_near_reg + div_quo : hue_near_reg - div_quo;
                    state_next = ST_KSTART;
                end
            end
            ST_KSTART:
            begin
                state_next = ST_KWAIT;
            end
            ST_KWAIT:
            begin
                // ceiling of 8*num/den, minus one for the table
                if (div_status.done)
                begin
                    note_next  = div_status.rem_nonzero ? div_quo[2:0] : div_quo[2:0] - 3'd1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    rgb_next   = hue_to_rgb(hue_reg);
                    tone_next  = note_hz(note_reg);
                    ton_next   = en_reg;
                    lvl_next   = avg_reg;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            avg_reg      <= '0;
            first_reg    <= 1'b1;
            ov_reg       <= 1'b0;
            near_reg     <= 9'd10;
            far_reg      <= 9'd50;
            hue_near_reg <= 8'd0;
            hue_far_reg  <= 8'd220;
            gain_reg     <= 17'd5243;
            cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            avg_reg   <= avg_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_NEAR_LIMIT: near_reg     <= cfg_data[LIMIT_W-1:0];
                    REG_FAR_LIMIT:  far_reg      <= cfg_data[LIMIT_W-1:0];
                    REG_HUE_NEAR:   hue_near_reg <= cfg_data[HUE_W-1:0];
                    REG_HUE_FAR:    hue_far_reg  <= cfg_data[HUE_W-1:0];
                    REG_GAIN:       gain_reg     <= cfg_data[GAIN_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg <= echo_next;
        en_reg   <= en_next;
        mul_reg  <= mul_next;
        dist_reg <= dist_next;
        g_reg    <= g_next;
        h_reg    <= h_next;
        ema_reg  <= ema_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        span_reg <= span_next;
        up_reg   <= up_next;
        sp_reg   <= sp_next;
        hue_reg  <= hue_next;
        note_reg <= note_next;
        rgb_reg  <= rgb_next;
        tone_reg <= tone_next;
        ton_reg  <= ton_next;
        lvl_reg  <= lvl_next;
    end

endmodule

`default_nettype wire

FILE: tb/sv/dtc_checker.sv
// checker for distance_to_color_and_tone: watches both channels, predicts each result
// from its own model of smoothing, hue mapping and note choice, and counts mismatches
// depends on dtc_pkg for widths and register indexes
`timescale 1ns / 1ps

module dtc_checker
    import dtc_pkg::*;
#(
    parameter int WIDTH_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [WIDTH_BITS-1:0] echo_us,
    input  wire logic                  sound_enable,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [COLOR_W-1:0]    red,
    input  wire logic [COLOR_W-1:0]    green,
    input  wire logic [COLOR_W-1:0]    blue,
    input  wire logic [TONE_W-1:0]     tone_hz,
    input  wire logic                  tone_on,
    input  wire logic [LEVEL_W-1:0]    level_q16,
    output int                         errors,
    output int                         pending,
    output int                         results_seen
);

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [9:0]  hz;
        logic        on;
        logic [30:0] level;
    } reading_t;

    localparam longint unsigned CM_PER_US_Q16 = 1114;

    reading_t          expected_readings[$];
    logic [8:0]        near_cm, far_cm;
    logic [7:0]        hue_lo, hue_hi;
    logic [16:0]       gain;
    longint unsigned   avg;
    logic              first_pending;

    function automatic logic [9:0] note_of(input int k);
        case (k)
            0: return 10'd261;
            1: return 10'd294;
            2: return 10'd330;
            3: return 10'd349;
            4: return 10'd392;
            5: return 10'd440;
            6: return 10'd493;
            default: return 10'd523;
        endcase
    endfunction

    function automatic logic [23:0] color_of(input logic [7:0] hue);
        int h6, rem;
        logic [7:0] q, t;
        h6  = int'(hue) * 6;
        rem = h6 % 256;
        t   = rem[7:0];
        q   = 8'd255 - t;
        case (h6 / 256)
            0: return {8'd255, t, 8'd0};
            1: return {q, 8'd255, 8'd0};
            2: return {8'd0, 8'd255, t};
            3: return {8'd0, q, 8'd255};
            4: return {t, 8'd0, 8'd255};
            default: return {8'd255, 8'd0, q};
        endcase
    endfunction

    // advance the smoother on a nonzero echo and build the expected reading
    task automatic smooth_and_map(input logic [WIDTH_BITS-1:0] echo, input logic en);
        longint unsigned range_q16, g, acc, nq, fq, num, den, k;
        logic [7:0] hue;
        logic [9:0] hz;
        reading_t rd;
        if (echo != 0) begin
            range_q16 = longint'(echo) * CM_PER_US_Q16;
            if (range_q16 > 64'h7FFF_FFFF) range_q16 = 64'h7FFF_FFFF;
            if (first_pending) begin
                avg = range_q16;
                first_pending = 1'b0;
            end else begin
                g   = (gain > 17'd65536) ? 65536 : gain;
                acc = range_q16 * g + avg * (65536 - g) + 32768;
                avg = (acc >> 16) & 64'h7FFF_FFFF;
            end
        end
        nq = longint'(near_cm) << 16;
        fq = longint'(far_cm) << 16;
        if (avg <= nq) begin
            hue = hue_lo;
            hz  = note_of(0);
        end else if (avg >= fq) begin
            hue = hue_hi;
            hz  = note_of(7);
        end else begin
            num = avg - nq;
            den = fq - nq;
            if (hue_hi >= hue_lo) hue = hue_lo + 8'((longint'(hue_hi - hue_lo) * num) / den);
            else hue = hue_lo - 8'((longint'(hue_lo - hue_hi) * num) / den);
            k = (8 * num + den - 1) / den;
            if (k < 1) k = 1;
            if (k > 8) k = 8;
            hz = note_of(int'(k) - 1);
        end
        {rd.r, rd.g, rd.b} = color_of(hue);
        rd.hz    = hz;
        rd.on    = en;
        rd.level = avg[30:0];
        expected_readings.push_back(rd);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            near_cm <= 9'd10; far_cm <= 9'd50; hue_lo <= 8'd0; hue_hi <= 8'd220;
            gain <= 17'd5243; avg = 0; first_pending = 1'b1;
            errors <= 0; results_seen <= 0; pending <= 0;
            expected_readings.delete();
        end
        else
        begin
            if (cfg_write)
                case (cfg_index)
                    REG_NEAR_LIMIT: near_cm <= cfg_data[8:0];
                    REG_FAR_LIMIT:  far_cm  <= cfg_data[8:0];
                    REG_HUE_NEAR:   hue_lo  <= cfg_data[7:0];
                    REG_HUE_FAR:    hue_hi  <= cfg_data[7:0];
                    REG_GAIN:       gain    <= cfg_data[16:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
                smooth_and_map(echo_us, sound_enable);
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none", $time);
                    $display("%0t:          actual r=%0d g=%0d b=%0d hz=%0d on=%0d lvl=%0d",
                             $time, red, green, blue, tone_hz, tone_on, level_q16);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if ({red, green, blue, tone_hz, tone_on, level_q16} != want)
                    begin
                        $display("%0t: mismatch expected r=%0d g=%0d b=%0d hz=%0d on=%0d lvl=%0d",
                                 $time, want.r, want.g, want.b, want.hz, want.on, want.level);
                        $display("%0t:          actual r=%0d g=%0d b=%0d hz=%0d on=%0d lvl=%0d",
                                 $time, red, green, blue, tone_hz, tone_on, level_q16);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_readings.size();
        end
    end

endmodule

FILE: tb/sv/tb_distance_to_color_and_tone.sv
// testbench top for distance_to_color_and_tone: drives echo items and config phases,
// stalls the result side at random, and gives the verdict from the checker's count
// depends on dtc_pkg, dtc_checker and the block itself
`timescale 1ns / 1ps

module tb_distance_to_color_and_tone;
    import dtc_pkg::*;

    localparam int WIDTH_BITS = 20;
    localparam longint CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [INDEX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [WIDTH_BITS-1:0] echo_us;
    logic                  sound_enable;
    logic                  out_valid;
    logic                  out_ready;
    logic [COLOR_W-1:0]    red, green, blue;
    logic [TONE_W-1:0]     tone_hz;
    logic                  tone_on;
    logic [LEVEL_W-1:0]    level_q16;
    int                    errors, pending, results_seen;
    longint                cycles;
    bit                    calm_sink;

    distance_to_color_and_tone #(.WIDTH_BITS(WIDTH_BITS), .FRAC_BITS(16)) u_dut (.*);

    dtc_checker #(.WIDTH_BITS(WIDTH_BITS)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on total cycles
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("distance_to_color_and_tone test failed");
            $finish;
        end
    end

    // result side: random stall per item, with quiet stretches
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = calm_sink ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // one item: optional gap, then hold valid until accepted
    task automatic send_echo(input logic [WIDTH_BITS-1:0] echo, input logic en, input int gap);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        echo_us      <= echo;
        sound_enable <= en;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // quiesce: everything back, then ride out the block's longest latency
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // mostly plausible ranges (up to ~6 m), plus zeros and the whole field
    function automatic logic [WIDTH_BITS-1:0] pick_echo();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return WIDTH_BITS'($urandom);
        if (sel == 2) return '1;
        return WIDTH_BITS'($urandom_range(1, 35000));
    endfunction

    task automatic random_phase(input int count);
        int gap;
        for (int i = 0; i < count; i++)
        begin
            gap = calm_sink ? 0 : $urandom_range(0, 11);
            send_echo(pick_echo(), 1'($urandom), gap);
            if (i % 100 == 50) calm_sink = ~calm_sink;
        end
    endtask

    initial
    begin
        logic [8:0] n, f;
        rst_n = 1'b0; in_valid = 1'b0; echo_us = '0; sound_enable = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0; cycles = 0;
        calm_sink = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no reading yet: zero echo with the reset average, then first load
        send_echo('0, 1'b1, 0);
        send_echo(WIDTH_BITS'(1176), 1'b0, 0);
        // extremes of the echo field and the largest distance
        send_echo('1, 1'b1, 2);
        send_echo(WIDTH_BITS'(1), 1'b1, 0);
        send_echo('0, 1'b0, 0);
        send_echo(WIDTH_BITS'(20'h80000), 1'b1, 1);
        for (int i = 0; i < 8; i++) send_echo(WIDTH_BITS'(600 + i * 300), i[0], 0);
        drain();

        // gain above one, reversed hue span, extreme hues, unknown index ignored
        write_reg(REG_GAIN, 17'h1FFFF);
        write_reg(REG_HUE_NEAR, 8'd255);
        write_reg(REG_HUE_FAR, 8'd0);
        write_reg(3'd7, 17'h1234);
        for (int i = 0; i < 6; i++) send_echo(WIDTH_BITS'(500 + i * 500), 1'b1, 0);
        drain();

        // limits crossed and equal, zero gain
        write_reg(REG_NEAR_LIMIT, 9'd400);
        write_reg(REG_FAR_LIMIT, 9'd0);
        write_reg(REG_GAIN, 17'd0);
        send_echo(WIDTH_BITS'(5000), 1'b1, 0);
        send_echo(WIDTH_BITS'(30000), 1'b0, 0);
        drain();
        write_reg(REG_FAR_LIMIT, 9'd400);
        write_reg(REG_GAIN, 17'd65536);
        send_echo(WIDTH_BITS'(12000), 1'b1, 0);
        drain();

        // random phases, each under a fresh register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            n = 9'($urandom_range(0, 400));
            f = 9'($urandom_range(0, 400));
            if (ph % 3 != 2 && n > f) {n, f} = {f, n};
            write_reg(REG_NEAR_LIMIT, n);
            write_reg(REG_FAR_LIMIT, f);
            write_reg(REG_HUE_NEAR, 8'($urandom));
            write_reg(REG_HUE_FAR, 8'($urandom));
            write_reg(REG_GAIN, (ph == 3) ? 17'h1FFFF : 17'($urandom_range(0, 65536)));
            random_phase(150);
            drain();
        end

        $display("covered directed edge cases and 8 random register settings");
        $display("%0d results checked", results_seen);
        if (errors == 0)
            $display("distance_to_color_and_tone test passed");
        else
            $display("distance_to_color_and_tone test failed");
        $finish;
    end

endmodule

FILE: distance_to_color_and_tone.f
design/dtc_pkg.sv
design/dtc_divider.sv
design/distance_to_color_and_tone.sv
tb/sv/dtc_checker.sv
tb/sv/tb_distance_to_color_and_tone.sv
